@@ rtl/vpts_pkg.sv @@
`timescale 1ns / 1ps

package vpts_pkg;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POS_W   = 3;

   localparam logic CMD_NUMBER = 1'b0;
   localparam logic CMD_CHAR   = 1'b1;

   localparam logic [BYTE_W-1:0] VARINT_MORE = 8'h80;
   localparam logic [CHAR_W-1:0] CHAR_MASK   = 7'h7F;
   localparam logic [POS_W-1:0]  POS_LAST    = 3'h7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NUMBER,
      ST_CHAR_EMIT,
      ST_CHAR_FLUSH
   } state_type;

   typedef struct packed {
      logic               emit;
      logic [BYTE_W-1:0]  emit_byte;
      logic               flush;
      logic [BYTE_W-1:0]  pend_next;
      logic [POS_W-1:0]   pos_next;
   } pack_res_type;

endpackage

@@ rtl/vpts_pack.sv @@
`timescale 1ns / 1ps

module vpts_pack (
   input  logic [vpts_pkg::CHAR_W-1:0] char_code,
   input  logic                        last_char,
   input  logic [vpts_pkg::POS_W-1:0]  pos,
   input  logic [vpts_pkg::BYTE_W-1:0] pend,
   output vpts_pkg::pack_res_type      res
);

   logic [vpts_pkg::BYTE_W-1:0]   hi_part;
   logic [vpts_pkg::BYTE_W-1:0]   lo_byte;
   logic [vpts_pkg::POS_W-1:0]    pos_adv;
   logic [vpts_pkg::CHAR_W-1:0]   c;

   assign c       = char_code & vpts_pkg::CHAR_MASK;
   assign hi_part = {1'b0, c} >> (vpts_pkg::POS_LAST - pos);
   assign lo_byte = {c, 1'b0} << pos;
   assign pos_adv = pos + 3'd1;

   always_comb begin
      res.emit      = (pos != '0);
      res.emit_byte = pend | hi_part;
      res.flush     = last_char && (pos_adv != '0);
      res.pend_next = last_char ? '0 : lo_byte;
      res.pos_next  = last_char ? '0 : pos_adv;
   end

endmodule

@@ rtl/varint_and_packed_text_serializer.sv @@
`timescale 1ns / 1ps
// number item: 1 to ceil(NUMBER_WIDTH/7) bytes, one per cycle unless the output stalls,
//   7 bits each from the number shift register; input stalled until its last byte is registered
// character item: 0, 1 or 2 bytes from the packing unit
// results leave through a registered output stage, loaded from the sequencer state entered on accept
// synchronous active-high reset clears the sequencer, pack position, pending bits and rsp_valid

module varint_and_packed_text_serializer #(
   parameter int unsigned NUMBER_WIDTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [vpts_pkg::VALUE_W-1:0] req_value,
   input  logic                         req_last_char,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [vpts_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                         rsp_run_end
);

   vpts_pkg::state_type state_ff, state_in;

   logic [NUMBER_WIDTH-1:0]         num_ff, num_in;
   logic [NUMBER_WIDTH-1:0]         num_rest;
   logic                            num_more;
   logic [vpts_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [vpts_pkg::BYTE_W-1:0]     pend_ff, pend_in;
   logic [vpts_pkg::BYTE_W-1:0]     char_byte_ff, char_byte_in;
   logic [vpts_pkg::BYTE_W-1:0]     flush_byte_ff, flush_byte_in;
   logic                            flush_ff, flush_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [vpts_pkg::BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                            rsp_end_ff, rsp_end_in;

   logic                            req_take;
   logic                            out_free;
   logic                            out_load;
   logic [vpts_pkg::BYTE_W-1:0]     out_byte;
   logic                            out_end;
   vpts_pkg::pack_res_type          pack_res;

   vpts_pack u_pack (
      .char_code (req_value[vpts_pkg::CHAR_W-1:0]),
      .last_char (req_last_char),
      .pos       (pos_ff),
      .pend      (pend_ff),
      .res       (pack_res)
   );

   assign req_stall = (state_ff != vpts_pkg::ST_IDLE);
   assign req_take  = req_valid && (state_ff == vpts_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign num_rest  = num_ff >> 7;
   assign num_more  = (num_rest != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vpts_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_cmd == vpts_pkg::CMD_NUMBER) begin
                  state_in = vpts_pkg::ST_NUMBER;
               end else if (pack_res.emit) begin
                  state_in = vpts_pkg::ST_CHAR_EMIT;
               end else if (pack_res.flush) begin
                  state_in = vpts_pkg::ST_CHAR_FLUSH;
               end
            end
         end
         vpts_pkg::ST_NUMBER: begin
            if (out_free && !num_more) begin
               state_in = vpts_pkg::ST_IDLE;
            end
         end
         vpts_pkg::ST_CHAR_EMIT: begin
            if (out_free) begin
               state_in = flush_ff ? vpts_pkg::ST_CHAR_FLUSH : vpts_pkg::ST_IDLE;
            end
         end
         vpts_pkg::ST_CHAR_FLUSH: begin
            if (out_free) begin
               state_in = vpts_pkg::ST_IDLE;
            end
         end
         default: state_in = vpts_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      out_load = 1'b0;
      out_byte = '0;
      out_end  = 1'b0;
      unique case (state_ff)
         vpts_pkg::ST_NUMBER: begin
            out_load = out_free;
            out_byte = {1'b0, num_ff[vpts_pkg::CHAR_W-1:0]}
                     | (num_more ? vpts_pkg::VARINT_MORE : 8'h00);
            out_end  = !num_more;
         end
         vpts_pkg::ST_CHAR_EMIT: begin
            out_load = out_free;
            out_byte = char_byte_ff;
            out_end  = !flush_ff;
         end
         vpts_pkg::ST_CHAR_FLUSH: begin
            out_load = out_free;
            out_byte = flush_byte_ff;
            out_end  = 1'b1;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      num_in        = num_ff;
      pos_in        = pos_ff;
      pend_in       = pend_ff;
      char_byte_in  = char_byte_ff;
      flush_byte_in = flush_byte_ff;
      flush_in      = flush_ff;
      if (req_take) begin
         if (req_cmd == vpts_pkg::CMD_NUMBER) begin
            num_in  = req_value[NUMBER_WIDTH-1:0];
            pos_in  = '0;
            pend_in = '0;
         end else begin
            char_byte_in  = pack_res.emit_byte;
            flush_in      = pack_res.flush;
            flush_byte_in = 8'({req_value[vpts_pkg::CHAR_W-1:0], 1'b0} << pos_ff);
            pos_in        = pack_res.pos_next;
            pend_in       = pack_res.pend_next;
         end
      end else if ((state_ff == vpts_pkg::ST_NUMBER) && out_free) begin
         num_in = num_rest;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = out_byte;
         rsp_end_in   = out_end;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vpts_pkg::ST_IDLE;
         pos_ff       <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff        <= num_in;
      char_byte_ff  <= char_byte_in;
      flush_byte_ff <= flush_byte_in;
      flush_ff      <= flush_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_end  = rsp_end_ff;

endmodule
